/* rtl/core/gtgn_pkg.sv */
// gtgn_pkg: shared types, constants and the heading sine/cosine tables
// for the go-to-goal navigator; no dependencies
package gtgn_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int FULL_TURN        = 5760;
  localparam int HALF_TURN        = FULL_TURN / 2;
  localparam int OBST_BEARING     = 320;
  localparam int TAN1_Q24         = 292847;
  localparam int DRIVE_ON         = 200;
  localparam int TURN_SLOW        = 10;
  localparam int TURN_FAST        = 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // heading to table index: num = hm * DEPTH + half turn, idx = num / FULL_TURN
  localparam int NUM_W       = 13 + $clog2(SINE_TABLE_DEPTH) + 1;
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / FULL_TURN;
  localparam int RECIP_W     = $clog2(RECIP + 1);

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_X   = 3'd0;
  localparam logic [2:0] REG_TARGET_Y   = 3'd1;
  localparam logic [2:0] REG_TARGET_HDG = 3'd2;
  localparam logic [2:0] REG_OBST_DIST  = 3'd3;
  localparam logic [2:0] REG_ARRIVE     = 3'd4;
  localparam logic [2:0] REG_HDG_TOL    = 3'd5;

  // shared multiplier operations, in issue order
  typedef enum logic [3:0] {
    OP_HXDY = 4'd0,
    OP_HYDX = 4'd1,
    OP_HXDX = 4'd2,
    OP_HYDY = 4'd3,
    OP_DXDX = 4'd4,
    OP_DYDY = 4'd5,
    OP_AA   = 4'd6,
    OP_DLT  = 4'd7,
    OP_DHT  = 4'd8
  } mul_op_t;

  localparam int MUL_OPS = 9;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    idx_num;
    logic    idx_q;
    logic    idx_fix;
    logic    mul_en;
    mul_op_t mul_op;
    logic    decide;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  typedef logic signed [16:0] trig_t;
  typedef trig_t trig_tab_t [SINE_TABLE_DEPTH];

  // taylor term divisors (2n)(2n+1) as Q64 reciprocals rounded up,
  // exact quotients for term magnitudes below 2^34
  localparam logic [127:0] TAYLOR_RECIP [10] = '{
    (128'd1 << 64) / 128'd6   + 128'd1,
    (128'd1 << 64) / 128'd20  + 128'd1,
    (128'd1 << 64) / 128'd42  + 128'd1,
    (128'd1 << 64) / 128'd72  + 128'd1,
    (128'd1 << 64) / 128'd110 + 128'd1,
    (128'd1 << 64) / 128'd156 + 128'd1,
    (128'd1 << 64) / 128'd210 + 128'd1,
    (128'd1 << 64) / 128'd272 + 128'd1,
    (128'd1 << 64) / 128'd342 + 128'd1,
    (128'd1 << 64) / 128'd420 + 128'd1
  };

  // sin(pi/2 * r / DEPTH) in Q15 by integer Taylor series
  function automatic trig_t quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint          sum;
    logic [127:0]    prod;
    begin
      x   = (r * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2  = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        prod = {64'd0, ((mag * x2) >> 30)} * TAYLOR_RECIP[n - 1];
        mag  = prod[127:64];
        if (n % 2 == 1) sum = sum - longint'(mag);
        else sum = sum + longint'(mag);
      end
      if (sum < 0) sum = 0;
      quarter_sine = trig_t'((longint'(sum) + (64'sd1 <<< 14)) >>> 15);
    end
  endfunction

  // sin(2*pi * num / (4*DEPTH)) in Q15
  function automatic trig_t wave(longint unsigned num);
    longint unsigned q;
    longint unsigned r;
    begin
      q = (num / SINE_TABLE_DEPTH) % 4;
      r = num % SINE_TABLE_DEPTH;
      case (q)
        0: wave = quarter_sine(r);
        1: wave = quarter_sine(SINE_TABLE_DEPTH - r);
        2: wave = -quarter_sine(r);
        default: wave = -quarter_sine(SINE_TABLE_DEPTH - r);
      endcase
    end
  endfunction

  function automatic trig_tab_t build_tab(int offset);
    trig_tab_t t;
    begin
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
        t[k] = wave(longint'(4 * k + offset));
      end
      build_tab = t;
    end
  endfunction

  localparam trig_tab_t SIN_TAB = build_tab(0);
  localparam trig_tab_t COS_TAB = build_tab(SINE_TABLE_DEPTH);

endpackage

/* rtl/core/gtgn_ctrl.sv */
// gtgn_ctrl: sequencer for one navigation tick
// depends on gtgn_pkg (command and status structs, multiplier op order)
module gtgn_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gtgn_pkg::dp_status_t  status,
  output gtgn_pkg::dp_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_Q, S_FIX, S_ROM, S_MUL, S_DRAIN, S_DECIDE
  } state_t;

  state_t state;
  logic [3:0] op_cnt;

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.mul_op  = gtgn_pkg::mul_op_t'(op_cnt);
    cmd.load    = in_valid && (state == S_IDLE);
    cmd.idx_num = (state == S_NUM);
    cmd.idx_q   = (state == S_Q);
    cmd.idx_fix = (state == S_FIX);
    cmd.mul_en  = (state == S_MUL);
    cmd.decide  = (state == S_DECIDE) && !status.out_busy;
  end

  // state and op counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_NUM;
        S_NUM:  state <= S_Q;
        S_Q:    state <= S_FIX;
        S_FIX:  state <= S_ROM;
        S_ROM: begin
          state  <= S_MUL;
          op_cnt <= '0;
        end
        S_MUL: begin
          if (op_cnt == 4'(gtgn_pkg::MUL_OPS - 1)) state <= S_DRAIN;
          else op_cnt <= op_cnt + 4'd1;
        end
        S_DRAIN: state <= S_DECIDE;
        S_DECIDE: if (!status.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mul_only_in_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |-> op_cnt < 4'(gtgn_pkg::MUL_OPS))
    else $error("op counter out of range");
  a_drain_after_mul: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> $past(state) == S_MUL)
    else $error("drain not after last multiply");
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_NUM)
    else $error("accepted tick did not start");
`endif

endmodule

/* rtl/core/gtgn_datapath.sv */
// gtgn_datapath: config registers, heading tables, shared multiplier,
// navigation state and the result register; depends on gtgn_pkg
module gtgn_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  gtgn_pkg::dp_cmd_t     cmd,
  output gtgn_pkg::dp_status_t  status,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic signed [15:0]    robot_x,
  input  logic signed [15:0]    robot_y,
  input  logic signed [12:0]    robot_heading,
  input  logic [14:0]           sonar_range,
  input  logic signed [12:0]    sonar_angle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            drive_speed,
  output logic signed [5:0]     turn_speed,
  output logic                  obstacle_seen,
  output logic                  goal_reached
);

  localparam int D = gtgn_pkg::SINE_TABLE_DEPTH;
  localparam int IW = gtgn_pkg::IDX_W;
  localparam int NW = gtgn_pkg::NUM_W;
  localparam int RW = gtgn_pkg::RECIP_W;

  // configuration registers
  logic signed [15:0] target_x, target_y;
  logic signed [12:0] target_heading;
  logic [14:0]        obstacle_distance, arrive_distance;
  logic [11:0]        heading_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x          <= '0;
      target_y          <= '0;
      target_heading    <= '0;
      obstacle_distance <= 15'd200;
      arrive_distance   <= 15'd50;
      heading_tolerance <= 12'd80;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gtgn_pkg::REG_TARGET_X:   target_x          <= cfg_data;
        gtgn_pkg::REG_TARGET_Y:   target_y          <= cfg_data;
        gtgn_pkg::REG_TARGET_HDG: target_heading    <= cfg_data[12:0];
        gtgn_pkg::REG_OBST_DIST:  obstacle_distance <= cfg_data[14:0];
        gtgn_pkg::REG_ARRIVE:     arrive_distance   <= cfg_data[14:0];
        gtgn_pkg::REG_HDG_TOL:    heading_tolerance <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // input capture and heading wrap
  logic signed [16:0] dx, dy;
  logic signed [12:0] rh;
  logic [14:0]        srange;
  logic signed [12:0] sangle;
  logic [12:0]        hm;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx     <= 17'(target_x) - 17'(robot_x);
      dy     <= 17'(target_y) - 17'(robot_y);
      rh     <= robot_heading;
      srange <= sonar_range;
      sangle <= sonar_angle;
      hm     <= (robot_heading < 0) ?
                13'(14'(robot_heading) + 14'(gtgn_pkg::FULL_TURN)) :
                13'(robot_heading);
    end
  end

  // table index by reciprocal multiply and one correction step
  logic [NW-1:0]    num_r;
  logic [IW:0]      q0_r;
  logic [IW-1:0]    idx_r;
  logic [NW+RW-1:0] qprod;
  logic [NW-1:0]    rem;
  logic [IW:0]      q1;

  assign qprod = (NW+RW)'(num_r) * (NW+RW)'(gtgn_pkg::RECIP);
  assign rem   = num_r - NW'(q0_r * NW'(gtgn_pkg::FULL_TURN));
  assign q1    = q0_r + ((rem >= NW'(gtgn_pkg::FULL_TURN)) ? (IW+1)'(1) : '0);

  always_ff @(posedge clk) begin
    if (cmd.idx_num) num_r <= NW'(hm) * NW'(D) + NW'(gtgn_pkg::HALF_TURN);
    if (cmd.idx_q) q0_r <= qprod[gtgn_pkg::RECIP_SHIFT +: IW+1];
    if (cmd.idx_fix) idx_r <= (q1 >= (IW+1)'(D)) ? '0 : q1[IW-1:0];
  end

  // registered table reads
  gtgn_pkg::trig_t sin_q, cos_q;
  always_ff @(posedge clk) begin
    sin_q <= gtgn_pkg::SIN_TAB[idx_r];
    cos_q <= gtgn_pkg::COS_TAB[idx_r];
  end

  // shared multiplier, one product per cycle
  logic signed [17:0] hx, hy, mul_a;
  logic signed [19:0] mul_b;
  logic signed [37:0] prod_r;
  gtgn_pkg::mul_op_t  prod_op;
  logic               prod_valid;
  logic signed [35:0] xprod, dot, d2, a2, dlt, dht;

  assign hx = -18'(sin_q);
  assign hy = 18'(cos_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      gtgn_pkg::OP_HXDY: begin mul_a = hx; mul_b = 20'(dy); end
      gtgn_pkg::OP_HYDX: begin mul_a = hy; mul_b = 20'(dx); end
      gtgn_pkg::OP_HXDX: begin mul_a = hx; mul_b = 20'(dx); end
      gtgn_pkg::OP_HYDY: begin mul_a = hy; mul_b = 20'(dy); end
      gtgn_pkg::OP_DXDX: begin mul_a = 18'(dx); mul_b = 20'(dx); end
      gtgn_pkg::OP_DYDY: begin mul_a = 18'(dy); mul_b = 20'(dy); end
      gtgn_pkg::OP_AA: begin
        mul_a = $signed({3'b000, arrive_distance});
        mul_b = $signed({5'b00000, arrive_distance});
      end
      gtgn_pkg::OP_DLT: begin
        mul_a = $signed({1'b0, dot[16:0]});
        mul_b = 20'(gtgn_pkg::TAN1_Q24);
      end
      gtgn_pkg::OP_DHT: begin
        mul_a = $signed({2'b00, dot[32:17]});
        mul_b = 20'(gtgn_pkg::TAN1_Q24);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) prod_valid <= 1'b0;
    else prod_valid <= cmd.mul_en;
    if (cmd.mul_en) begin
      prod_r  <= 38'(mul_a) * 38'(mul_b);
      prod_op <= cmd.mul_op;
    end
  end

  // accumulate each product the cycle after it is formed
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      case (prod_op)
        gtgn_pkg::OP_HXDY: xprod <= 36'(prod_r);
        gtgn_pkg::OP_HYDX: xprod <= xprod - 36'(prod_r);
        gtgn_pkg::OP_HXDX: dot   <= 36'(prod_r);
        gtgn_pkg::OP_HYDY: dot   <= dot + 36'(prod_r);
        gtgn_pkg::OP_DXDX: d2    <= 36'(prod_r);
        gtgn_pkg::OP_DYDY: d2    <= d2 + 36'(prod_r);
        gtgn_pkg::OP_AA:   a2    <= 36'(prod_r);
        gtgn_pkg::OP_DLT:  dlt   <= 36'(prod_r);
        gtgn_pkg::OP_DHT:  dht   <= 36'(prod_r);
        default: ;
      endcase
    end
  end

  // decision for one tick
  logic [7:0]         drive_reg, drv_next;
  logic signed [6:0]  turn_reg, trn_next;
  logic               facing, at_pos, at_hdg;
  logic               fac_next, pos_next, hdg_next, obst;
  logic [35:0]        across;
  logic [59:0]        lhs, rhs;
  logic               aligned;
  logic signed [13:0] diff, tol;

  // low partial product is unsigned and may use all 36 bits
  assign across  = xprod[35] ? 36'(-xprod) : 36'(xprod);
  assign lhs     = {across, 24'd0};
  assign rhs     = {7'd0, dht[35:0], 17'd0} + {24'd0, dlt};
  assign aligned = (dot > 0) && (lhs < rhs);
  assign diff    = 14'(rh) - 14'(target_heading);
  assign tol     = $signed({2'b00, heading_tolerance});
  assign obst    = (srange <= obstacle_distance) &&
                   (sangle <= 13'(gtgn_pkg::OBST_BEARING)) &&
                   (sangle >= -13'(gtgn_pkg::OBST_BEARING));

  always_comb begin
    drv_next = drive_reg;
    trn_next = turn_reg;
    fac_next = facing;
    pos_next = at_pos;
    hdg_next = at_hdg;
    if (obst) begin
      fac_next = 1'b0;
      drv_next = 8'(gtgn_pkg::DRIVE_ON);
      trn_next = (sangle > 0) ? -7'(gtgn_pkg::TURN_FAST) : 7'(gtgn_pkg::TURN_FAST);
    end else begin
      // steer toward the target
      if (!facing) begin
        if (aligned) begin
          trn_next = '0;
          fac_next = 1'b1;
        end else begin
          drv_next = '0;
          trn_next = (xprod >= 0) ? 7'(gtgn_pkg::TURN_SLOW) : -7'(gtgn_pkg::TURN_SLOW);
          fac_next = 1'b0;
        end
      end else begin
        drv_next = 8'(gtgn_pkg::DRIVE_ON);
      end
      // arrival and final heading
      if (!at_pos) begin
        if (d2 < a2) pos_next = 1'b1;
      end else if (!at_hdg) begin
        drv_next = '0;
        if (diff > tol) trn_next = -7'(gtgn_pkg::TURN_SLOW);
        else if (diff < -tol) trn_next = 7'(gtgn_pkg::TURN_SLOW);
        else begin
          hdg_next = 1'b1;
          trn_next = '0;
        end
      end else begin
        trn_next = '0;
        drv_next = '0;
      end
    end
  end

  // persistent state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_reg <= '0;
      turn_reg  <= '0;
      facing    <= 1'b0;
      at_pos    <= 1'b0;
      at_hdg    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decide) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.decide) begin
        drive_reg     <= drv_next;
        turn_reg      <= trn_next;
        facing        <= fac_next;
        at_pos        <= pos_next;
        at_hdg        <= hdg_next;
        drive_speed   <= drv_next;
        turn_speed    <= trn_next[5:0];
        obstacle_seen <= obst;
        goal_reached  <= pos_next && hdg_next;
      end
    end
  end

  assign status.out_busy = out_valid && !out_ready;

`ifndef SYNTHESIS
  a_heading_after_position: assert property (@(posedge clk) disable iff (rst)
    at_hdg |-> at_pos)
    else $error("heading reached before position");
  a_drive_levels: assert property (@(posedge clk) disable iff (rst)
    drive_reg == 8'd0 || drive_reg == 8'(gtgn_pkg::DRIVE_ON))
    else $error("drive speed not 0 or full");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !(out_valid && !out_ready))
    else $error("result overwritten before transfer");
  a_goal_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(at_pos) && !$past(rst) |-> at_pos)
    else $error("position flag cleared");
`endif

endmodule

/* rtl/core/go_to_goal_navigator.sv */
// go_to_goal_navigator: top level, stream ports and configuration port
// depends on gtgn_pkg, gtgn_ctrl and gtgn_datapath
//
// Usage:
//   One input transfer on s_axis is one control tick (pose and nearest
//   sonar echo); it yields exactly one result transfer on m_axis with the
//   drive and turn commands and two flags.
//   Registers are written on the cfg channel (cfg_ready is always high) at
//   index 0..5: target_x, target_y, target_heading, obstacle_distance,
//   arrive_distance, heading_tolerance; other indexes are ignored. Write
//   them only while no tick is in flight.
//   After the input transfer the tick runs the heading-to-index steps
//   (num, quotient, correction) and one table read; the shared 18x20
//   multiplier then takes nine products per tick, a drain state follows,
//   and the decision writes the result; a new tick is taken only in idle.
//   Reset (rst, synchronous) restores register defaults and clears the
//   stored speeds and the facing/position/heading flags (not the m_axis fields).
//   If m_axis stalls, the result waits in its register; the next tick is
//   still accepted and runs up to its decision, then waits for the slot.
module go_to_goal_navigator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // robot_x[15:0], robot_y[31:16], robot_heading[44:32],
  // sonar_range[59:45], sonar_angle[72:60], zero fill [79:73]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_speed[7:0], turn_speed[13:8], obstacle_seen[14], goal_reached[15]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  gtgn_pkg::dp_cmd_t    cmd;
  gtgn_pkg::dp_status_t status;
  logic [7:0]           drive_speed;
  logic signed [5:0]    turn_speed;
  logic                 obstacle_seen;
  logic                 goal_reached;

  assign cfg_ready = 1'b1;

  gtgn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gtgn_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .robot_x       ($signed(s_axis_tdata[15:0])),
    .robot_y       ($signed(s_axis_tdata[31:16])),
    .robot_heading ($signed(s_axis_tdata[44:32])),
    .sonar_range   (s_axis_tdata[59:45]),
    .sonar_angle   ($signed(s_axis_tdata[72:60])),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .drive_speed   (drive_speed),
    .turn_speed    (turn_speed),
    .obstacle_seen (obstacle_seen),
    .goal_reached  (goal_reached)
  );

  // pack the result
  assign m_axis_tdata = {goal_reached, obstacle_seen, turn_speed, drive_speed};

endmodule
